>>> design/hmmv_pkg.sv
// ----------------------------------------------------------------------------
// hmmv_pkg
// Shared types and constants for the log-domain HMM Viterbi decoder.
// ----------------------------------------------------------------------------
package hmmv_pkg;

    localparam int VAL_W   = 16;
    localparam int SCORE_W = 24;

    localparam logic signed [VAL_W-1:0]   LOG_ZERO   = 16'sh8000;
    localparam logic signed [SCORE_W-1:0] SCORE_ZERO = 24'sh800000;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX  = 24'sh7FFFFF;

    typedef enum logic [1:0] {
        ACT_LOAD_TRANS = 2'd0,
        ACT_LOAD_EMIS  = 2'd1,
        ACT_LOAD_INIT  = 2'd2,
        ACT_OBSERVE    = 2'd3
    } t_action;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic init_mode;
        logic e_zero;
    } t_acs_ctl;

endpackage

>>> design/hmmv_ram.sv
// ----------------------------------------------------------------------------
// hmmv_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hmmv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/hmmv_acs.sv
// ----------------------------------------------------------------------------
// hmmv_acs
// Add-compare-select unit: saturating log-domain sum, running best and argmax.
// ----------------------------------------------------------------------------
module hmmv_acs
    import hmmv_pkg::*;
#(
    parameter int SW = 5
) (
    input  logic                      i_clk,
    input  t_acs_ctl                  i_ctl,
    input  logic [SW-1:0]             i_k,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic signed [VAL_W-1:0]   i_init,
    input  logic signed [VAL_W-1:0]   i_trans,
    input  logic signed [VAL_W-1:0]   i_emis,
    output logic                      o_wr,
    output logic signed [SCORE_W-1:0] o_best,
    output logic [SW-1:0]             o_arg
);

    logic signed [SCORE_W-1:0] r_best, n_best;
    logic [SW-1:0]             r_arg, n_arg;
    logic signed [SCORE_W-1:0] base;
    logic signed [VAL_W-1:0]   trans;
    logic                      zero;
    logic signed [SCORE_W+1:0] sum;
    logic signed [SCORE_W-1:0] s;
    logic                      take;

    always_comb begin
        base  = i_ctl.init_mode ? SCORE_W'(i_init) : i_score;
        trans = i_ctl.init_mode ? '0 : i_trans;
        zero  = (i_ctl.init_mode ? (i_init == LOG_ZERO) : (i_score == SCORE_ZERO))
              || (trans == LOG_ZERO) || (i_emis == LOG_ZERO) || i_ctl.e_zero;
        sum   = (SCORE_W+2)'(base) + (SCORE_W+2)'(trans) + (SCORE_W+2)'(i_emis);
        if (zero || sum <= (SCORE_W+2)'(SCORE_ZERO)) begin
            s = SCORE_ZERO;
        end else if (sum > (SCORE_W+2)'(SCORE_MAX)) begin
            s = SCORE_MAX;
        end else begin
            s = SCORE_W'(sum);
        end
        take   = i_ctl.first || (s > r_best);
        n_best = take ? s : r_best;
        n_arg  = take ? i_k : r_arg;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_best <= n_best;
            r_arg  <= n_arg;
        end
    end

    assign o_wr   = i_ctl.vld && i_ctl.last;
    assign o_best = n_best;
    assign o_arg  = n_arg;

endmodule

>>> design/hmm_viterbi_decoder_top.sv
// ----------------------------------------------------------------------------
// hmm_viterbi_decoder_top
// Log-domain HMM Viterbi decoder: table loads, forward pass, traceback.
//
// Channel  Dir  Handshake                        Payload
// s_axis   in   i_s_axis_tvalid/o_s_axis_tready  tdata, tuser (action), tlast
// m_axis   out  o_m_axis_tvalid/i_m_axis_tready  tdata, tlast (last_result)
//
// Load item: written in S_IDLE. First observation: S_INIT over all states, then
// S_FDRAIN. Later observation: S_FWD, one predecessor per cycle through the
// single ACS unit and the one-read-port memories, then S_FDRAIN. The last one
// adds a final scan, S_TB_SCAN and S_TB_DRAIN, then S_OUT for each result and
// S_BP_WAIT between results. Synchronous active-low reset clears control only;
// tables are undefined until loaded. Output stalls hold the traceback in place.
// ----------------------------------------------------------------------------
module hmm_viterbi_decoder_top
    import hmmv_pkg::*;
#(
    parameter int NUM_STATES  = 32,
    parameter int NUM_SYMBOLS = 64,
    parameter int MAX_LEN     = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // row[4:0] col[10:5] value[26:11] symbol[32:27]
    input  logic [1:0]  i_s_axis_tuser,  // action[1:0]
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // state_index[4:0] position[10:5]
    output logic        o_m_axis_tlast
);

    localparam int SW  = $clog2(NUM_STATES);
    localparam int TAW = $clog2(NUM_STATES * NUM_STATES);
    localparam int EAW = $clog2(NUM_STATES * NUM_SYMBOLS);
    localparam int SAW = $clog2(2 * NUM_STATES);
    localparam int BAW = $clog2(MAX_LEN * NUM_STATES);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_INIT     = 8'b0000_0010,
        S_FWD      = 8'b0000_0100,
        S_FDRAIN   = 8'b0000_1000,
        S_TB_SCAN  = 8'b0001_0000,
        S_TB_DRAIN = 8'b0010_0000,
        S_OUT      = 8'b0100_0000,
        S_BP_WAIT  = 8'b1000_0000
    } t_state;

    t_state                    r_state;
    logic [6:0]                r_count;
    logic                      r_cur, r_wcol, r_last, r_e_zero;
    logic [5:0]                r_sym, r_p;
    logic [SW-1:0]             r_i, r_k, r_q, r_rd_i, r_rd_k, r_tb_i;
    t_acs_ctl                  r_rd, n_rd;
    logic                      r_tb_vld;
    logic signed [SCORE_W-1:0] r_tb_best;

    logic [4:0]              in_row;
    logic [5:0]              in_col, in_sym;
    logic signed [VAL_W-1:0] in_val;
    t_action                 in_act;
    logic                    acc, is_last_i, is_last_k, out_acc;

    logic signed [VAL_W-1:0]   trans_rd, emis_rd, init_rd;
    logic signed [SCORE_W-1:0] score_rd, acs_best;
    logic [SW-1:0]             bp_rd, acs_arg;
    logic                      acs_wr;

    assign in_row = i_s_axis_tdata[4:0];
    assign in_col = i_s_axis_tdata[10:5];
    assign in_val = $signed(i_s_axis_tdata[26:11]);
    assign in_sym = i_s_axis_tdata[32:27];
    assign in_act = t_action'(i_s_axis_tuser);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc         = o_m_axis_tvalid && i_m_axis_tready;
    assign is_last_i       = (r_i == SW'(NUM_STATES - 1));
    assign is_last_k       = (r_k == SW'(NUM_STATES - 1));

    logic we_trans, we_emis, we_init;
    assign we_trans = acc && (in_act == ACT_LOAD_TRANS)
                    && ({27'd0, in_row} < NUM_STATES) && ({26'd0, in_col} < NUM_STATES);
    assign we_emis  = acc && (in_act == ACT_LOAD_EMIS)
                    && ({27'd0, in_row} < NUM_STATES) && ({26'd0, in_col} < NUM_SYMBOLS);
    assign we_init  = acc && (in_act == ACT_LOAD_INIT) && ({27'd0, in_row} < NUM_STATES);

    hmmv_ram #(.WIDTH(VAL_W), .DEPTH(NUM_STATES * NUM_STATES)) u_trans (
        .i_clk   (i_clk),
        .i_we    (we_trans),
        .i_waddr (TAW'(in_row) * TAW'(NUM_STATES) + TAW'(in_col)),
        .i_wdata (in_val),
        .i_raddr (TAW'(r_k) * TAW'(NUM_STATES) + TAW'(r_i)),
        .o_rdata (trans_rd)
    );

    hmmv_ram #(.WIDTH(VAL_W), .DEPTH(NUM_STATES * NUM_SYMBOLS)) u_emis (
        .i_clk   (i_clk),
        .i_we    (we_emis),
        .i_waddr (EAW'(in_row) * EAW'(NUM_SYMBOLS) + EAW'(in_col)),
        .i_wdata (in_val),
        .i_raddr (EAW'(r_i) * EAW'(NUM_SYMBOLS) + EAW'(r_sym)),
        .o_rdata (emis_rd)
    );

    hmmv_ram #(.WIDTH(VAL_W), .DEPTH(NUM_STATES)) u_init (
        .i_clk   (i_clk),
        .i_we    (we_init),
        .i_waddr (SW'(in_row)),
        .i_wdata (in_val),
        .i_raddr (r_i),
        .o_rdata (init_rd)
    );

    logic [SAW-1:0] score_raddr;
    assign score_raddr = SAW'(r_cur) * SAW'(NUM_STATES)
                       + SAW'((r_state == S_FWD) ? r_k : r_i);

    hmmv_ram #(.WIDTH(SCORE_W), .DEPTH(2 * NUM_STATES)) u_score (
        .i_clk   (i_clk),
        .i_we    (acs_wr),
        .i_waddr (SAW'(r_wcol) * SAW'(NUM_STATES) + SAW'(r_rd_i)),
        .i_wdata (acs_best),
        .i_raddr (score_raddr),
        .o_rdata (score_rd)
    );

    hmmv_ram #(.WIDTH(SW), .DEPTH(MAX_LEN * NUM_STATES)) u_bp (
        .i_clk   (i_clk),
        .i_we    (acs_wr && !r_rd.init_mode),
        .i_waddr (BAW'(r_count) * BAW'(NUM_STATES) + BAW'(r_rd_i)),
        .i_wdata (acs_arg),
        .i_raddr (BAW'(r_p) * BAW'(NUM_STATES) + BAW'(r_q)),
        .o_rdata (bp_rd)
    );

    hmmv_acs #(.SW(SW)) u_acs (
        .i_clk   (i_clk),
        .i_ctl   (r_rd),
        .i_k     (r_rd_k),
        .i_score (score_rd),
        .i_init  (init_rd),
        .i_trans (trans_rd),
        .i_emis  (emis_rd),
        .o_wr    (acs_wr),
        .o_best  (acs_best),
        .o_arg   (acs_arg)
    );

    always_comb begin
        n_rd           = '0;
        n_rd.vld       = (r_state == S_INIT) || (r_state == S_FWD);
        n_rd.init_mode = (r_state == S_INIT);
        n_rd.first     = (r_state == S_INIT) || (r_k == '0);
        n_rd.last      = (r_state == S_INIT) || is_last_k;
        n_rd.e_zero    = r_e_zero;
    end

    always_ff @(posedge i_clk) begin
        r_rd_i <= r_i;
        r_rd_k <= r_k;
        r_tb_i <= r_i;
        if (r_tb_vld && ((r_tb_i == '0) || (score_rd > r_tb_best))) begin
            r_tb_best <= score_rd;
            r_q       <= r_tb_i;
        end
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cur    <= 1'b0;
            r_rd     <= '0;
            r_tb_vld <= 1'b0;
        end else begin
            r_rd     <= n_rd;
            r_tb_vld <= (r_state == S_TB_SCAN);
            case (r_state)
                S_IDLE: begin
                    if (acc && in_act == ACT_OBSERVE) begin
                        r_sym    <= in_sym;
                        r_e_zero <= ({26'd0, in_sym} >= NUM_SYMBOLS);
                        r_last   <= i_s_axis_tlast;
                        r_i      <= '0;
                        r_k      <= '0;
                        if (r_count == '0) begin
                            r_wcol  <= 1'b0;
                            r_state <= S_INIT;
                        end else if (r_count < 7'(MAX_LEN)) begin
                            r_wcol  <= ~r_cur;
                            r_state <= S_FWD;
                        end else if (i_s_axis_tlast) begin
                            r_state <= S_TB_SCAN;
                        end
                    end
                end
                S_INIT: begin
                    r_i <= r_i + 1'b1;
                    if (is_last_i) begin
                        r_state <= S_FDRAIN;
                    end
                end
                S_FWD: begin
                    r_k <= r_k + 1'b1;
                    if (is_last_k) begin
                        r_k <= '0;
                        r_i <= r_i + 1'b1;
                        if (is_last_i) begin
                            r_state <= S_FDRAIN;
                        end
                    end
                end
                S_FDRAIN: begin
                    r_cur   <= r_wcol;
                    r_count <= r_count + 1'b1;
                    r_i     <= '0;
                    r_state <= r_last ? S_TB_SCAN : S_IDLE;
                end
                S_TB_SCAN: begin
                    r_i <= r_i + 1'b1;
                    if (is_last_i) begin
                        r_state <= S_TB_DRAIN;
                    end
                end
                S_TB_DRAIN: begin
                    r_p     <= 6'(r_count - 1'b1);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_acc) begin
                        if (r_p == '0) begin
                            r_count <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_BP_WAIT;
                        end
                    end
                end
                S_BP_WAIT: begin
                    r_q     <= bp_rd;
                    r_p     <= r_p - 1'b1;
                    r_state <= S_OUT;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = {5'd0, r_p, 5'(r_q)};
    assign o_m_axis_tlast  = (r_p == '0);

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("result offered while input accepted");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 7'(MAX_LEN))
        else $error("observation count beyond sequence length");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ({1'b0, r_p} < r_count))
        else $error("position outside held sequence");

    a_tb_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_m_axis_tlast) |=> (r_state == S_IDLE) && (r_count == '0))
        else $error("traceback did not return to idle");
`endif

endmodule
